### src/twma_pkg.sv
// shared constants and helpers of the trailing multi-window average unit
package twma_pkg;

	localparam int LONGEST_DEF  = 120;
	localparam int SAMPLE_DEF   = 16;
	localparam int SAMPLE_W     = 16;
	localparam int AVG_W        = 16;
	localparam int WIN_COUNT    = 6;
	localparam int OUT_DATA_W   = AVG_W * WIN_COUNT;
	localparam int SHORT_DEPTH  = 32;
	localparam int TAP_DEPTH    = 5;

	localparam int WIN_THREE    = 3;
	localparam int WIN_FIVE     = 5;
	localparam int WIN_TEN      = 10;
	localparam int WIN_THIRTY   = 30;
	localparam int WIN_SIXTY    = 60;

	// window length by slot, the last slot is the longest window
	function automatic int win_len(input int k, input int longest);
		int len;
		unique case (k)
			0: len = WIN_THREE;
			1: len = WIN_FIVE;
			2: len = WIN_TEN;
			3: len = WIN_THIRTY;
			4: len = WIN_SIXTY;
			default: len = longest;
		endcase
		return len;
	endfunction

endpackage

### src/twma_ram.sv
// generic simple dual port ram, one write port and two registered read ports
module twma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read of the entry being written returns the old value
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

### src/trailing_multi_window_average_unit.sv
// top level of the trailing multi-window average unit
// Takes one unsigned Q8.8 sample per beat and returns, for that beat, the truncated means
// of the 3, 5, 10, 30, 60 and LONGEST_WINDOW samples that came before it (the current
// sample is not counted). ready_mask bit k is set once window k has seen that many samples
// since reset or the last restart; an unready window reports 0. A restart flag in tuser
// empties the history before its own sample. One beat is accepted every clock cycle while
// downstream takes results. The rate is set by the running-sum loop, one add and one
// subtract per window each cycle, with history read from two small rams in the cycle
// before its use. Downstream backpressure stalls the whole pipeline. History memory needs
// no clearing pass: entries are only used once the fill count proves them written.
module trailing_multi_window_average_unit #(
	parameter int LONGEST_WINDOW = twma_pkg::LONGEST_DEF,
	parameter int SAMPLE_BITS    = twma_pkg::SAMPLE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [twma_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // sample
	input  logic [0:0]                        s_axis_tuser,   // restart
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// avg_three, avg_five, avg_ten, avg_thirty, avg_sixty, avg_long
	output logic [twma_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [twma_pkg::WIN_COUNT-1:0]    m_axis_tuser    // ready_mask
);
	import twma_pkg::*;

	localparam int FILL_W = $clog2(LONGEST_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + FILL_W;
	localparam int PA_W   = $clog2(LONGEST_WINDOW);
	localparam int PB_W   = $clog2(SHORT_DEPTH);
	localparam int M_W    = SUM_W + 1;
	localparam int P_W    = SUM_W + M_W;

	// handshake: every stage moves when the output register can move
	logic adv, acc;
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign acc           = s_axis_tvalid && adv;

	logic [SAMPLE_BITS-1:0] smp;
	assign smp = SAMPLE_BITS'(s_axis_tdata);

	// fill count and ring pointers
	logic [FILL_W-1:0] fill_q, fill_eff;
	logic [PA_W-1:0]   wpa_q, ra_sixty;
	logic [PB_W-1:0]   wpb_q;
	assign fill_eff = s_axis_tuser[0] ? '0 : fill_q;
	assign ra_sixty = (wpa_q >= PA_W'(WIN_SIXTY)) ? wpa_q - PA_W'(WIN_SIXTY)
		: wpa_q + PA_W'(LONGEST_WINDOW - WIN_SIXTY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wpa_q  <= '0;
			wpb_q  <= '0;
		end else if (acc) begin
			fill_q <= (fill_eff == FILL_W'(LONGEST_WINDOW)) ? fill_eff
				: fill_eff + FILL_W'(1);
			wpa_q  <= (wpa_q == PA_W'(LONGEST_WINDOW - 1)) ? '0 : wpa_q + PA_W'(1);
			wpb_q  <= wpb_q + PB_W'(1);
		end
	end

	// per-window readiness at accept
	logic [WIN_COUNT-1:0] rdy_in;

	// long history: oldest entry (same address as the write, read-first) and sixty back
	logic [SAMPLE_BITS-1:0] rd_long, rd_sixty, rd_thirty, rd_ten;

	twma_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LONGEST_WINDOW)) u_ram_long (
		.clk     (clk),
		.we      (acc),
		.waddr   (wpa_q),
		.wdata   (smp),
		.re      (adv),
		.raddr_a (wpa_q),
		.raddr_b (ra_sixty),
		.rdata_a (rd_long),
		.rdata_b (rd_sixty)
	);

	// short history, power-of-two ring so pointers wrap by themselves
	twma_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SHORT_DEPTH)) u_ram_short (
		.clk     (clk),
		.we      (acc),
		.waddr   (wpb_q),
		.wdata   (smp),
		.re      (adv),
		.raddr_a (wpb_q - PB_W'(WIN_THIRTY)),
		.raddr_b (wpb_q - PB_W'(WIN_TEN)),
		.rdata_a (rd_thirty),
		.rdata_b (rd_ten)
	);

	// the two shortest windows take their leaving sample from a tap line
	logic [SAMPLE_BITS-1:0] taps_q [TAP_DEPTH];
	always_ff @(posedge clk) begin
		if (acc) begin
			taps_q[0] <= smp;
			for (int i = 1; i < TAP_DEPTH; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

	// stage 1: ram data arrives, running sums update
	logic                   v_s1, restart_s1;
	logic [WIN_COUNT-1:0]   rdy_s1;
	logic [SAMPLE_BITS-1:0] sample_s1, sub3_s1, sub5_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdy_s1     <= rdy_in;
			restart_s1 <= s_axis_tuser[0];
			sample_s1  <= smp;
			sub3_s1    <= taps_q[WIN_THREE - 1];
			sub5_s1    <= taps_q[WIN_FIVE - 1];
		end
	end

	logic [SAMPLE_BITS-1:0] sub   [WIN_COUNT];
	logic [SUM_W-1:0]       sums_q [WIN_COUNT];
	logic [SUM_W-1:0]       base  [WIN_COUNT];
	logic [SUM_W-1:0]       upd   [WIN_COUNT];

	assign sub[0] = sub3_s1;
	assign sub[1] = sub5_s1;
	assign sub[2] = rd_ten;
	assign sub[3] = rd_thirty;
	assign sub[4] = rd_sixty;
	assign sub[5] = rd_long;

	always_comb begin
		for (int k = 0; k < WIN_COUNT; k++) begin
			base[k] = restart_s1 ? '0 : sums_q[k];
			upd[k]  = base[k] + SUM_W'(sample_s1)
				- (rdy_s1[k] ? SUM_W'(sub[k]) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_COUNT; k++) begin
				sums_q[k] <= '0;
			end
		end else if (adv && v_s1) begin
			for (int k = 0; k < WIN_COUNT; k++) begin
				sums_q[k] <= upd[k];
			end
		end
	end

	// stage 2: sums before this sample, zero for an unready window
	logic                 v_s2, v_s3;
	logic [WIN_COUNT-1:0] rdy_s2, rdy_s3;
	logic [SUM_W-1:0]     pre_s2 [WIN_COUNT];
	logic [P_W-1:0]       prod_s3 [WIN_COUNT];
	logic [AVG_W-1:0]     avg_q [WIN_COUNT];
	logic [WIN_COUNT-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rdy_s2 <= rdy_s1;
			rdy_s3 <= rdy_s2;
			mask_q <= rdy_s3;
			for (int k = 0; k < WIN_COUNT; k++) begin
				pre_s2[k] <= rdy_s1[k] ? base[k] : '0;
			end
		end
	end

	// stage 3 and output: divide by window length as multiply by reciprocal and shift
	for (genvar k = 0; k < WIN_COUNT; k++) begin : g_win
		localparam int LEN = win_len(k, LONGEST_WINDOW);
		localparam int SH  = SUM_W + $clog2(LEN);
		localparam longint unsigned MUL = ((64'd1 << SH) + 64'(LEN) - 64'd1) / 64'(LEN);

		assign rdy_in[k] = fill_eff >= FILL_W'(LEN);

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s3[k] <= P_W'(pre_s2[k]) * P_W'(M_W'(MUL));
				avg_q[k]   <= AVG_W'(prod_s3[k] >> SH);
			end
		end

		assign m_axis_tdata[k*AVG_W +: AVG_W] = avg_q[k];
	end

	assign m_axis_tuser = mask_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LONGEST_WINDOW))
		else $error("fill count above longest window");

	a_restart_unready: assert property (@(posedge clk) disable iff (!arst_n)
		acc && s_axis_tuser[0] |=> v_s1 && (rdy_s1 == '0))
		else $error("window ready right after restart");

	a_mask_nested: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tuser[5] == 1'b0) || m_axis_tuser[4])
			&& ((m_axis_tuser[4] == 1'b0) || m_axis_tuser[3])
			&& ((m_axis_tuser[1] == 1'b0) || m_axis_tuser[0]))
		else $error("longer window ready before shorter one");

	a_unready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[AVG_W-1:0] == '0)
		else $error("unready window reports nonzero average");

endmodule
